[hw/rtl/sahmc_pkg.sv]
package sahmc_pkg;

  // fixed field widths
  localparam int ADDR_W     = 48;
  localparam int IN_DATA_W  = 48;
  localparam int CNT_W      = 32;
  localparam int OUT_DATA_W = 136;
  localparam int STAMP_W    = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  // set index before folding onto the sets present: up to seven bits
  localparam int SET_RAW_W  = 7;

  // parameter defaults
  localparam int SETS_DEF      = 64;
  localparam int WAYS_DEF      = 8;
  localparam int ADDR_BITS_DEF = 48;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS   = 2'd3;

  localparam logic POL_FIFO  = 1'b0;
  localparam logic POL_LRU   = 1'b1;
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_SCAN,
    ST_UPD
  } state_t;

  // status of one line against the lookup key
  typedef struct packed {
    logic valid;
    logic tag_eq;
    logic stamp_lt;
  } cmp_t;

endpackage

[hw/rtl/sahmc_line_store.sv]
module sahmc_line_store #(
  parameter int LINES   = 512,
  parameter int LINE_W  = 9,
  parameter int TAG_W   = 48
) (
  input  logic                         clk,
  input  logic                         rd_en,
  input  logic [LINE_W-1:0]            rd_addr,
  input  logic                         wr_en,
  input  logic [LINE_W-1:0]            wr_addr,
  input  logic                         wr_valid,
  input  logic [TAG_W-1:0]             wr_tag,
  input  logic [sahmc_pkg::STAMP_W-1:0] wr_stamp,
  input  logic [TAG_W-1:0]             key_tag,
  input  logic [sahmc_pkg::STAMP_W-1:0] key_stamp,
  output sahmc_pkg::cmp_t              cmp,
  output logic [sahmc_pkg::STAMP_W-1:0] rd_stamp
);

  localparam int WORD_W = 1 + TAG_W + sahmc_pkg::STAMP_W;

  // word: valid, tag, stamp from the top bit down
  logic [WORD_W-1:0] mem [LINES];
  logic [WORD_W-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_valid, wr_tag, wr_stamp};
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // shared compare unit on the registered line
  assign rd_stamp     = rd_q_r[sahmc_pkg::STAMP_W-1:0];
  assign cmp.valid    = rd_q_r[WORD_W-1];
  assign cmp.tag_eq   = (rd_q_r[WORD_W-2 -: TAG_W] == key_tag);
  assign cmp.stamp_lt = (rd_stamp < key_stamp);

endmodule

[hw/rtl/set_assoc_cache_hit_miss_counter.sv]
// channel | dir | handshake            | payload
// in      | in  | in_tvalid/in_tready  | in_tdata: address, in_tuser: action
// out     | out | out_tvalid/out_tready| out_tdata: hit, fill read, write, four totals
// cfg     | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// a request passes through these steps from acceptance to result:
//   acceptance, address split, a line read and compare for each way in use, update
// the way scan is set by the single read port of the line store and its compare unit
// after reset a clearing pass marks every one of the SETS*WAYS lines invalid;
//   no request is taken meanwhile, configuration writes are
// a result waits in the output register; the next request is accepted meanwhile
//   and only its update step holds until the register is free
module set_assoc_cache_hit_miss_counter #(
  parameter int SETS      = sahmc_pkg::SETS_DEF,
  parameter int WAYS      = sahmc_pkg::WAYS_DEF,
  parameter int ADDR_BITS = sahmc_pkg::ADDR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [sahmc_pkg::IN_DATA_W-1:0]     in_tdata,   // [47:0] address
  input  logic [0:0]                          in_tuser,   // [0] action
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] hit, [1] memory_read, [2] memory_write, [34:3] total_hits,
  // [66:35] total_misses, [98:67] total_reads, [130:99] total_writes, zero above
  output logic [sahmc_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sahmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sahmc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int ADDR_W    = sahmc_pkg::ADDR_W;
  localparam int CNT_W     = sahmc_pkg::CNT_W;
  localparam int STAMP_W   = sahmc_pkg::STAMP_W;
  localparam int SET_RAW_W = sahmc_pkg::SET_RAW_W;
  localparam int LINES     = SETS * WAYS;
  localparam int LINE_W    = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WAY_CNT_W = $clog2(WAYS + 1);
  localparam int TAG_W     = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam logic [ADDR_W-1:0] ADDR_MASK =
    (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} : ((ADDR_W'(1) << ADDR_BITS) - ADDR_W'(1));
  localparam int PAD_W     = sahmc_pkg::OUT_DATA_W - 3 - 4 * CNT_W;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

  // configuration registers
  logic       policy_r;
  logic [4:0] off_r;
  logic [2:0] idx_r;
  logic [3:0] ways_cfg_r;

  sahmc_pkg::state_t state_r, state_nxt;

  // request registers
  logic                 write_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [SET_W-1:0]     set_r;
  logic [TAG_W-1:0]     tag_r;
  logic [WAY_CNT_W-1:0] ways_r;

  // scan registers
  logic [WAY_CNT_W-1:0] rd_way_r;
  logic                 pend_r;
  logic [WAY_W-1:0]     pend_way_r;
  logic                 found_r, empty_r, vict_set_r;
  logic [WAY_W-1:0]     found_way_r, empty_way_r, vict_way_r;
  logic [STAMP_W-1:0]   vict_stamp_r;

  logic [LINE_W-1:0]    clr_cnt_r;
  logic [STAMP_W-1:0]   stamp_r, stamp_nxt;
  logic [CNT_W-1:0]     hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0]     miss_cnt_r, miss_cnt_nxt;
  logic [CNT_W-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0]     wr_cnt_r, wr_cnt_nxt;

  logic                            out_tvalid_r;
  logic [sahmc_pkg::OUT_DATA_W-1:0] out_tdata_r;

  // control
  logic                 out_free;
  logic                 scan_rd;
  logic                 upd_go;
  logic                 clr_wr;
  logic                 line_wr;
  logic [WAY_W-1:0]     wr_way;
  logic [LINE_W-1:0]    base;
  logic [LINE_W-1:0]    rd_addr;
  logic [LINE_W-1:0]    wr_addr;
  logic                 st_wr_en;
  sahmc_pkg::cmp_t      cmp;
  logic [STAMP_W-1:0]   rd_stamp;

  // address split
  logic [ADDR_W-1:0]    addr_m;
  logic [5:0]           tag_sh;
  logic [ADDR_W-1:0]    tag_full;
  logic [ADDR_W-1:0]    set_sh;
  logic [SET_RAW_W-1:0] set_mask;
  logic [SET_RAW_W-1:0] set_raw;
  logic [SET_W-1:0]     set_tab [2**SET_RAW_W];
  logic [WAY_CNT_W-1:0] ways_eff;

  // set index folded onto the sets present
  for (genvar g = 0; g < 2**SET_RAW_W; g++) begin : g_set_tab
    assign set_tab[g] = SET_W'(g % SETS);
  end

  assign addr_m   = addr_r & ADDR_MASK;
  assign tag_sh   = 6'(off_r) + 6'(idx_r);
  assign tag_full = addr_m >> tag_sh;
  assign set_sh   = addr_m >> off_r;
  assign set_mask = SET_RAW_W'((8'(1) << idx_r) - 8'(1));
  assign set_raw  = set_sh[SET_RAW_W-1:0] & set_mask;

  always_comb begin
    if (ways_cfg_r == 4'd0) begin
      ways_eff = WAY_CNT_W'(1);
    end else if (int'(ways_cfg_r) > WAYS) begin
      ways_eff = WAY_CNT_W'(WAYS);
    end else begin
      ways_eff = WAY_CNT_W'(ways_cfg_r);
    end
  end

  assign base    = LINE_W'(set_r * WAYS);
  assign rd_addr = base + LINE_W'(rd_way_r);
  assign wr_way  = found_r ? found_way_r : (empty_r ? empty_way_r : vict_way_r);
  assign wr_addr = clr_wr ? clr_cnt_r : base + LINE_W'(wr_way);
  assign st_wr_en = clr_wr | line_wr;
  assign out_free = !out_tvalid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sahmc_pkg::ST_CLEAR: begin
        if (clr_cnt_r == LINE_W'(LINES - 1)) state_nxt = sahmc_pkg::ST_IDLE;
      end
      sahmc_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = sahmc_pkg::ST_PREP;
      end
      sahmc_pkg::ST_PREP: begin
        state_nxt = sahmc_pkg::ST_SCAN;
      end
      sahmc_pkg::ST_SCAN: begin
        // the last compare lands in the scan registers at this edge
        if (!scan_rd) state_nxt = sahmc_pkg::ST_UPD;
      end
      sahmc_pkg::ST_UPD: begin
        if (out_free) state_nxt = sahmc_pkg::ST_IDLE;
      end
      default: state_nxt = sahmc_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready = 1'b0;
    scan_rd   = 1'b0;
    upd_go    = 1'b0;
    clr_wr    = 1'b0;
    unique case (state_r)
      sahmc_pkg::ST_CLEAR: clr_wr    = 1'b1;
      sahmc_pkg::ST_IDLE:  in_tready = 1'b1;
      sahmc_pkg::ST_PREP:  ;
      sahmc_pkg::ST_SCAN:  scan_rd   = (rd_way_r < ways_r);
      sahmc_pkg::ST_UPD:   upd_go    = out_free;
      default: ;
    endcase
  end

  // fifo keeps stamps on a hit, lru refreshes them
  assign line_wr = upd_go && (!found_r || policy_r == sahmc_pkg::POL_LRU);

  always_comb begin
    stamp_nxt    = line_wr ? stamp_r + STAMP_W'(1) : stamp_r;
    hit_cnt_nxt  = (upd_go && found_r) ? sat_inc(hit_cnt_r) : hit_cnt_r;
    miss_cnt_nxt = (upd_go && !found_r) ? sat_inc(miss_cnt_r) : miss_cnt_r;
    rd_cnt_nxt   = (upd_go && !found_r) ? sat_inc(rd_cnt_r) : rd_cnt_r;
    wr_cnt_nxt   = (upd_go && write_r == sahmc_pkg::ACT_WRITE) ? sat_inc(wr_cnt_r) : wr_cnt_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sahmc_pkg::ST_CLEAR;
      clr_cnt_r    <= '0;
      policy_r     <= sahmc_pkg::POL_FIFO;
      off_r        <= 5'd2;
      idx_r        <= 3'd6;
      ways_cfg_r   <= 4'd8;
      stamp_r      <= '0;
      hit_cnt_r    <= '0;
      miss_cnt_r   <= '0;
      rd_cnt_r     <= '0;
      wr_cnt_r     <= '0;
      out_tvalid_r <= 1'b0;
      pend_r       <= 1'b0;
      rd_way_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      stamp_r    <= stamp_nxt;
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
      rd_cnt_r   <= rd_cnt_nxt;
      wr_cnt_r   <= wr_cnt_nxt;
      if (clr_wr) begin
        clr_cnt_r <= clr_cnt_r + LINE_W'(1);
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          sahmc_pkg::CFG_POLICY: policy_r   <= cfg_data[0];
          sahmc_pkg::CFG_OFFSET: off_r      <= cfg_data;
          sahmc_pkg::CFG_INDEX:  idx_r      <= cfg_data[2:0];
          sahmc_pkg::CFG_WAYS:   ways_cfg_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (upd_go) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      // one line read in flight during the scan
      pend_r <= scan_rd;
      if (state_r == sahmc_pkg::ST_PREP) begin
        rd_way_r <= '0;
      end else if (scan_rd) begin
        rd_way_r <= rd_way_r + WAY_CNT_W'(1);
      end
    end
  end

  // request and scan payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      write_r <= in_tuser[0];
      addr_r  <= in_tdata;
    end
    if (state_r == sahmc_pkg::ST_PREP) begin
      set_r      <= set_tab[set_raw];
      tag_r      <= tag_full[TAG_W-1:0];
      ways_r     <= ways_eff;
      found_r    <= 1'b0;
      empty_r    <= 1'b0;
      vict_set_r <= 1'b0;
    end
    pend_way_r <= rd_way_r[WAY_W-1:0];
    if (pend_r) begin
      if (cmp.valid && cmp.tag_eq && !found_r) begin
        found_r     <= 1'b1;
        found_way_r <= pend_way_r;
      end
      if (!cmp.valid && !empty_r) begin
        empty_r     <= 1'b1;
        empty_way_r <= pend_way_r;
      end
      // smallest stamp among valid lines, lowest way on a tie
      if (cmp.valid && (!vict_set_r || cmp.stamp_lt)) begin
        vict_set_r   <= 1'b1;
        vict_way_r   <= pend_way_r;
        vict_stamp_r <= rd_stamp;
      end
    end
    if (upd_go) begin
      out_tdata_r <= {{PAD_W{1'b0}}, wr_cnt_nxt, rd_cnt_nxt, miss_cnt_nxt, hit_cnt_nxt,
                      write_r, !found_r, found_r};
    end
  end

  sahmc_line_store #(
    .LINES  (LINES),
    .LINE_W (LINE_W),
    .TAG_W  (TAG_W)
  ) u_store (
    .clk       (clk),
    .rd_en     (scan_rd),
    .rd_addr   (rd_addr),
    .wr_en     (st_wr_en),
    .wr_addr   (wr_addr),
    .wr_valid  (!clr_wr),
    .wr_tag    (tag_r),
    .wr_stamp  (stamp_r),
    .key_tag   (tag_r),
    .key_stamp (vict_stamp_r),
    .cmp       (cmp),
    .rd_stamp  (rd_stamp)
  );

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // an accepted request always moves on to the address split
  a_accept_prep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == sahmc_pkg::ST_PREP))
    else $error("accepted request did not reach address split");

  // a result is either a hit or a fill, never both
  a_hit_xor_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (out_tdata_r[0] != out_tdata_r[1]))
    else $error("hit and fill read flags disagree");

  // the hit and miss totals never go backwards outside reset
  a_hits_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (hit_cnt_r >= $past(hit_cnt_r)) && (miss_cnt_r >= $past(miss_cnt_r)))
    else $error("running total decreased");

  // the scan never reads past the ways in use
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sahmc_pkg::ST_SCAN) |-> (rd_way_r <= ways_r))
    else $error("way scan ran past ways in use");

  // the line store is written only by the clearing pass or the update step
  a_store_wr: assert property (@(posedge clk) disable iff (!rst_n)
    st_wr_en |-> (state_r == sahmc_pkg::ST_CLEAR || state_r == sahmc_pkg::ST_UPD))
    else $error("line store written outside clear or update");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import sahmc_pkg::*;

  localparam int SETS          = SETS_DEF;
  localparam int WAYS          = WAYS_DEF;
  localparam int LINES         = SETS * WAYS;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 94;
  localparam int CYCLE_LIMIT   = 400000;
  // extra wait after the last expected result, for anything still in flight
  localparam int DRAIN_CYCLES  = 24;
  localparam int REPORT_LIMIT  = 40;

  // one expected result, fields listed in out_tdata order from bit 0 upward
  typedef struct packed {
    logic        hit;
    logic        fill;
    logic        wr;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] reads;
    logic [31:0] writes;
  } access_result_t;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata   = '0;   // [47:0] address
  logic [0:0]              in_tuser   = '0;   // [0] action
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  // [0] hit, [1] memory_read, [2] memory_write, [34:3] total_hits,
  // [66:35] total_misses, [98:67] total_reads, [130:99] total_writes
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic                    cfg_valid  = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index  = '0;
  logic [CFG_DATA_W-1:0]   cfg_data   = '0;

  set_assoc_cache_hit_miss_counter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 20 ns period
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // cache mirror: tags, stamps and counters as the block should hold them
  // ---------------------------------------------------------------------------
  logic        mirror_valid [LINES];
  logic [47:0] mirror_tag   [LINES];
  logic [63:0] mirror_stamp [LINES];
  logic [63:0] stamp_next;
  logic [31:0] hit_total;
  logic [31:0] miss_total;
  logic [31:0] read_total;
  logic [31:0] write_total;

  // register copies, reset values as the block comes out of reset
  logic        policy_reg;
  logic [4:0]  offset_reg;
  logic [2:0]  index_reg;
  logic [3:0]  ways_reg;

  access_result_t pending_results[$];
  int             fail_count  = 0;
  int             cycle_count = 0;
  // set during one whole phase: neither side idles
  bit             steady_flow = 1'b0;

  function automatic void clear_mirror();
    for (int i = 0; i < LINES; i++) begin
      mirror_valid[i] = 1'b0;
      mirror_tag[i]   = '0;
      mirror_stamp[i] = '0;
    end
    stamp_next  = '0;
    hit_total   = '0;
    miss_total  = '0;
    read_total  = '0;
    write_total = '0;
    policy_reg  = POL_FIFO;
    offset_reg  = 5'd2;
    index_reg   = 3'd6;
    ways_reg    = 4'd8;
  endfunction

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  // zero ways behaves as direct mapped, anything past the ways present is clipped
  function automatic int active_ways();
    if (ways_reg == 4'd0) return 1;
    if (ways_reg > WAYS) return WAYS;
    return int'(ways_reg);
  endfunction

  // one access against the mirror: lookup, fill or evict, counter update
  function automatic access_result_t cache_lookup(logic act, logic [47:0] addr);
    logic [63:0]    a64;
    logic [63:0]    tag;
    int             shift;
    int             set_no;
    int             base;
    int             nways;
    int             found;
    int             empty;
    int             victim;
    access_result_t r;
    a64    = {16'd0, addr};
    nways  = active_ways();
    shift  = int'(offset_reg) + int'(index_reg);
    // set index wider than the sets present folds back onto them
    set_no = int'((a64 >> offset_reg) & ((64'd1 << index_reg) - 64'd1)) % SETS;
    tag    = a64 >> shift;
    base   = set_no * WAYS;
    found  = -1;
    empty  = -1;
    for (int w = 0; w < nways; w++) begin
      if (mirror_valid[base + w]) begin
        if (found < 0 && {16'd0, mirror_tag[base + w]} == tag) found = w;
      end else if (empty < 0) begin
        empty = w;
      end
    end
    r.hit = (found >= 0);
    if (r.hit) begin
      hit_total = sat_inc(hit_total);
      // lru refreshes the line on a hit, fifo leaves it alone
      if (policy_reg == POL_LRU) begin
        mirror_stamp[base + found] = stamp_next;
        stamp_next++;
      end
    end else begin
      victim = 0;
      if (empty >= 0) begin
        victim = empty;
      end else begin
        // oldest stamp goes, lowest way on a tie
        for (int w = 1; w < nways; w++)
          if (mirror_stamp[base + w] < mirror_stamp[base + victim]) victim = w;
      end
      mirror_valid[base + victim] = 1'b1;
      mirror_tag[base + victim]   = tag[47:0];
      mirror_stamp[base + victim] = stamp_next;
      stamp_next++;
      miss_total = sat_inc(miss_total);
      read_total = sat_inc(read_total);
    end
    if (act == ACT_WRITE) write_total = sat_inc(write_total);
    r.fill   = !r.hit;
    r.wr     = (act == ACT_WRITE);
    r.hits   = hit_total;
    r.misses = miss_total;
    r.reads  = read_total;
    r.writes = write_total;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request and configuration drivers
  // ---------------------------------------------------------------------------
  task automatic send_access(input logic act, input logic [47:0] addr);
    // random idle cycles ahead of the request, none in a steady phase
    while (!steady_flow && $urandom_range(99) < 34) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= addr;
    in_tuser  <= act;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(cache_lookup(act, addr));
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_POLICY: policy_reg = val[0];
      CFG_OFFSET: offset_reg = val[4:0];
      CFG_INDEX:  index_reg  = val[2:0];
      CFG_WAYS:   ways_reg   = val[3:0];
      default: ;
    endcase
  endtask

  // registers only change once every outstanding result is back
  task automatic set_config(input logic pol, input logic [4:0] off,
                            input logic [2:0] idx, input logic [3:0] ways);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    write_register(CFG_POLICY, {4'd0, pol});
    write_register(CFG_OFFSET, off);
    write_register(CFG_INDEX, {2'd0, idx});
    write_register(CFG_WAYS, {1'b0, ways});
    cfg_valid <= 1'b0;
  endtask

  // mostly a small working set of tags over a few neighbouring sets,
  // with a share of fully random addresses for noise
  function automatic logic [47:0] pick_address(logic [63:0] tag_base, int set_base);
    logic [63:0] a;
    logic [63:0] set_part;
    logic [63:0] low_part;
    int          shift;
    if ($urandom_range(99) < 20) begin
      a = {$urandom, $urandom};
      return a[47:0];
    end
    shift    = int'(offset_reg) + int'(index_reg);
    set_part = 64'(set_base + $urandom_range(2)) & ((64'd1 << index_reg) - 64'd1);
    low_part = {$urandom, $urandom} & ((64'd1 << offset_reg) - 64'd1);
    a = ((tag_base + 64'($urandom_range(active_ways() + 2))) << shift)
        | (set_part << offset_reg) | low_part;
    return a[47:0];
  endfunction

  // ---------------------------------------------------------------------------
  // result checker and receiver stalls
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    access_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
          $display("%0t: unexpected result, expected none, actual %0h", $time, out_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("hit",          {31'd0, want.hit},  {31'd0, out_tdata[0]});
        check_field("memory_read",  {31'd0, want.fill}, {31'd0, out_tdata[1]});
        check_field("memory_write", {31'd0, want.wr},   {31'd0, out_tdata[2]});
        check_field("total_hits",   want.hits,          out_tdata[34:3]);
        check_field("total_misses", want.misses,        out_tdata[66:35]);
        check_field("total_reads",  want.reads,         out_tdata[98:67]);
        check_field("total_writes", want.writes,        out_tdata[130:99]);
      end
    end
    out_tready <= steady_flow || ($urandom_range(99) >= 34);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[set_assoc_cache_hit_miss_counter] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset settings: fifo, 4-byte blocks, 64 sets, 8 ways; address extremes
  task automatic test_reset_settings();
    send_access(ACT_READ,  48'h0000_0000_0000);
    send_access(ACT_WRITE, 48'h0000_0000_0003);   // same block, hit
    send_access(ACT_READ,  48'hFFFF_FFFF_FFFF);
    send_access(ACT_WRITE, 48'hFFFF_FFFF_FFFF);
  endtask

  // one set, two ways: fifo evicts the oldest fill even after it was hit
  task automatic test_fifo_victim();
    set_config(POL_FIFO, 5'd0, 3'd0, 4'd2);
    send_access(ACT_READ,  48'h10);
    send_access(ACT_READ,  48'h20);
    send_access(ACT_WRITE, 48'h10);               // hit, stamp kept
    send_access(ACT_READ,  48'h30);               // evicts 0x10
    send_access(ACT_READ,  48'h10);
  endtask

  // same set under lru: a hit moves the line to the back of the queue
  task automatic test_lru_refresh();
    set_config(POL_LRU, 5'd0, 3'd0, 4'd2);
    send_access(ACT_READ,  48'h30);
    send_access(ACT_WRITE, 48'h40);
    send_access(ACT_READ,  48'h30);
    send_access(ACT_READ,  48'h10);               // evicts 0x40
  endtask

  // zero ways acts as direct mapped and oversized ways clip to all ways
  task automatic test_way_limits();
    set_config(POL_FIFO, 5'd16, 3'd0, 4'd0);
    send_access(ACT_READ,  48'h1_0000);
    send_access(ACT_WRITE, 48'h2_0000);
    send_access(ACT_READ,  48'h1_0000);
    set_config(POL_LRU, 5'd16, 3'd0, 4'd15);
    send_access(ACT_READ,  48'h2_0000);
    send_access(ACT_WRITE, 48'h1_0000);
  endtask

  // widest offset and index: set bits above the sets present fold back
  task automatic test_wide_split();
    set_config(POL_FIFO, 5'd31, 3'd7, 4'd8);
    send_access(ACT_READ,  48'hFFFF_FFFF_FFFF);
    send_access(ACT_READ,  48'h003F_8000_0000);
    send_access(ACT_WRITE, 48'hFFFF_FFFF_FFFF);
  endtask

  // phases of random traffic, each under its own settings
  task automatic test_random_traffic();
    logic [63:0] tag_base;
    int          set_base;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: set_config(POL_FIFO, 5'd2,  3'd6, 4'd8);
        1: set_config(POL_LRU,  5'd4,  3'd3, 4'd4);
        2: set_config(POL_FIFO, 5'd0,  3'd0, 4'd1);
        3: set_config(POL_LRU,  5'd16, 3'd6, 4'd8);
        4: set_config(POL_LRU,  5'd5,  3'd2, 4'd3);
        5: set_config(POL_FIFO, 5'd31, 3'd7, 4'd15);
        6: set_config(POL_LRU,  5'd1,  3'd1, 4'd0);
        default: set_config(1'($urandom_range(1)), 5'($urandom_range(16)),
                            3'($urandom_range(7)), 4'($urandom_range(15)));
      endcase
      // one phase runs flat out on both sides
      steady_flow = (p == 3);
      tag_base    = {$urandom, $urandom};
      set_base    = $urandom_range(SETS - 1);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_access(1'($urandom_range(1)), pick_address(tag_base, set_base));
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    clear_mirror();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // requests wait on in_tready through the clearing pass
    test_reset_settings();
    test_fifo_victim();
    test_lru_refresh();
    test_way_limits();
    test_wide_split();
    test_random_traffic();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[set_assoc_cache_hit_miss_counter] OK");
    end else begin
      $display("[set_assoc_cache_hit_miss_counter] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/sahmc_pkg.sv
hw/rtl/sahmc_line_store.sv
hw/rtl/set_assoc_cache_hit_miss_counter.sv
tb/testbench.sv
